FILE: rtl/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

  // Defaults and fixed widths
  localparam int PPT_SAMPLES       = 4;
  localparam int PPT_TIME_W        = 32;
  localparam int PPT_TIMEOUT_W     = 13;
  localparam int PPT_TIMEOUT_RESET = 500;
  localparam int PPT_US_PER_MS     = 1000;
  localparam int PPT_LIMIT_W       = 23;
  localparam int PPT_RPM_NUM       = 60000000;
  localparam int PPT_RPM_W         = 16;

  // Input command codes
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic pulse;      // record a pulse word
    logic query;      // capture liveness for a query word
    logic clr_quo;    // query takes the zero-speed path
    logic load_mean;  // low partial product of sum * (1 / SAMPLES)
    logic mean_hi;    // add the high partial product, giving the mean
    logic load_rate;  // start RPM_NUM / mean
    logic step;       // one divider iteration
    logic out_load;   // load the result register
  } ppt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go_div;     // ring full and signal live for the incoming query
    logic div_last;   // divider is on its final iteration
  } ppt_sts_t;

endpackage

`default_nettype wire

FILE: rtl/pulse_period_tachometer.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall    in_command, in_now_us
// out_      output     out_valid / out_stall  out_rpm, out_alive
// cfg_      input      cfg_we                 cfg_wdata (timeout in ms)
//
// A pulse word never stalls the input. A query word forms the mean by a
// reciprocal multiply in two steps, loads the bit-serial divider, takes one
// divide step per bit of the 32 + clog2(SAMPLES) bit sum and loads the result;
// a query that reads zero speed goes straight to loading the result.
// Reset (rst_n low, synchronous) empties the history and sets a 500 ms timeout.
// A finished result waits in the output register while pulse words go on.
`default_nettype none

module pulse_period_tachometer
  import ppt_pkg::*;
#(
  parameter int SAMPLES = PPT_SAMPLES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_command,
  input  wire logic [PPT_TIME_W-1:0]    in_now_us,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [PPT_RPM_W-1:0]          out_rpm,
  output logic                          out_alive,
  input  wire logic                     cfg_we,
  input  wire logic [PPT_TIMEOUT_W-1:0] cfg_wdata
);

  ppt_cmd_t cmd;
  ppt_sts_t sts;

  ppt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ppt_dp #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_now_us (in_now_us),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_rpm   (out_rpm),
    .out_alive (out_alive)
  );

endmodule

`default_nettype wire

FILE: rtl/ppt_ctrl.sv
`default_nettype none

module ppt_ctrl
  import ppt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_command,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire ppt_sts_t sts,
  output ppt_cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MEAN  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_RATE  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequence each word; a query runs through the mean multiply and the divider
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_PULSE) begin
            cmd.pulse = 1'b1;
          end else begin
            cmd.query = 1'b1;
            if (sts.go_div) begin
              cmd.load_mean = 1'b1;
              state_nxt     = ST_MEAN;
            end else begin
              cmd.clr_quo = 1'b1;
              state_nxt   = ST_DONE;
            end
          end
        end
      end
      ST_MEAN: begin
        cmd.mean_hi = 1'b1;
        state_nxt   = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.load_rate = 1'b1;
        state_nxt     = ST_RATE;
      end
      ST_RATE: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ppt_dp.sv
`default_nettype none

module ppt_dp
  import ppt_pkg::*;
#(
  parameter int SAMPLES = PPT_SAMPLES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [PPT_TIME_W-1:0]    in_now_us,
  input  wire logic                     cfg_we,
  input  wire logic [PPT_TIMEOUT_W-1:0] cfg_wdata,
  input  wire ppt_cmd_t                 cmd,
  output ppt_sts_t                      sts,
  output logic [PPT_RPM_W-1:0]          out_rpm,
  output logic                          out_alive
);

  localparam int SLOT_W = $clog2(SAMPLES);
  localparam int SUM_W  = PPT_TIME_W + $clog2(SAMPLES);
  localparam int CNT_W  = $clog2(SUM_W);
  localparam logic [PPT_LIMIT_W-1:0] LIMIT_RESET =
    PPT_LIMIT_W'(PPT_TIMEOUT_RESET * PPT_US_PER_MS);

  // Reciprocal of SAMPLES: floor(x / SAMPLES) = (x * RECIP) >> RECIP_SH for x < 2^SUM_W
  localparam int RECIP_SH = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W  = SUM_W + 1;
  localparam int LO_W     = RECIP_W / 2;
  localparam int HI_W     = RECIP_W - LO_W;
  localparam int ACC_W    = SUM_W + LO_W;
  localparam int PART_W   = SUM_W + HI_W;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:LO_W];

  // Pulse history
  logic [PPT_TIME_W-1:0]  ring_r [SAMPLES];
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [PPT_TIME_W-1:0]  last_r;
  logic                   first_seen_r, ring_full_r, ring_full_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [PPT_LIMIT_W-1:0] limit_r;

  // Mean multiply, divider and result
  logic [ACC_W-1:0]       acc_r;
  logic [SUM_W-1:0]       rem_r, quo_r, dvs_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   alive_r;
  logic [PPT_RPM_W-1:0]   out_rpm_r;
  logic                   out_alive_r;

  logic [PPT_TIME_W-1:0]  period;
  logic [PPT_TIME_W-1:0]  old_period;
  logic                   live_now;
  logic [HI_W-1:0]        mul_k;
  logic [PART_W-1:0]      part;
  logic [PROD_W-1:0]      prod;
  logic [SUM_W:0]         rem_ext;
  logic [SUM_W:0]         rem_diff;
  logic                   fits;
  logic [PPT_RPM_W-1:0]   rpm_sat;

  // Elapsed time since the last pulse, also the new period
  assign period   = in_now_us - last_r;
  assign live_now = (period <= PPT_TIME_W'(limit_r));

  // Report query path and divider progress
  always_comb begin
    sts.go_div   = ring_full_r && live_now;
    sts.div_last = (cnt_r == '0);
  end

  // Entries not yet written since reset count as zero
  assign old_period = ring_full_r ? ring_r[slot_r] : '0;
  assign sum_nxt    = sum_r + SUM_W'(period) - SUM_W'(old_period);

  // Advance the write slot modulo SAMPLES
  always_comb begin
    slot_nxt      = slot_r + SLOT_W'(1);
    ring_full_nxt = ring_full_r;
    if (slot_r == SLOT_W'(SAMPLES - 1)) begin
      slot_nxt      = '0;
      ring_full_nxt = 1'b1;
    end
  end

  // Pulse bookkeeping and timeout limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= '0;
      last_r       <= '0;
      first_seen_r <= 1'b0;
      ring_full_r  <= 1'b0;
      sum_r        <= '0;
      limit_r      <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= PPT_LIMIT_W'(cfg_wdata) * PPT_LIMIT_W'(PPT_US_PER_MS);
      end
      if (cmd.pulse) begin
        if (first_seen_r) begin
          slot_r      <= slot_nxt;
          ring_full_r <= ring_full_nxt;
          sum_r       <= sum_nxt;
        end
        first_seen_r <= 1'b1;
        last_r       <= in_now_us;
      end
    end
  end

  // Store the new period
  always_ff @(posedge clk) begin
    if (cmd.pulse && first_seen_r) begin
      ring_r[slot_r] <= period;
    end
  end

  // Mean as sum * RECIP, low half of the constant first, high half next cycle
  assign mul_k = cmd.load_mean ? HI_W'(RECIP_LO) : RECIP_HI;
  assign part  = PART_W'(sum_r) * PART_W'(mul_k);
  assign prod  = PROD_W'(acc_r) + (PROD_W'(part) << LO_W);

  // One restoring division step
  assign rem_ext  = {rem_r, quo_r[SUM_W-1]};
  assign rem_diff = rem_ext - {1'b0, dvs_r};
  assign fits     = !rem_diff[SUM_W];

  // Serial divider for RPM_NUM / mean.
  // A zero mean yields an all-ones quotient, which saturates below.
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      alive_r <= first_seen_r && live_now;
    end
    if (cmd.clr_quo) begin
      quo_r <= '0;
    end else if (cmd.load_mean) begin
      acc_r <= part[ACC_W-1:0];
    end else if (cmd.mean_hi) begin
      dvs_r <= SUM_W'(prod[RECIP_SH +: PPT_TIME_W]);
    end else if (cmd.load_rate) begin
      rem_r <= '0;
      quo_r <= SUM_W'(PPT_RPM_NUM);
      cnt_r <= CNT_W'(SUM_W - 1);
    end else if (cmd.step) begin
      rem_r <= fits ? rem_diff[SUM_W-1:0] : rem_ext[SUM_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Clamp the quotient to the output range
  assign rpm_sat = (|quo_r[SUM_W-1:PPT_RPM_W]) ? '1 : quo_r[PPT_RPM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rpm_r   <= rpm_sat;
      out_alive_r <= alive_r;
    end
  end

  assign out_rpm   = out_rpm_r;
  assign out_alive = out_alive_r;

endmodule

`default_nettype wire

FILE: rtl/ppt_checker.sv
`default_nettype none

module ppt_checker
  import ppt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  in_command,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [PPT_RPM_W-1:0]  out_rpm,
  input wire logic                  out_alive
);

  // Reset drops any pending result word
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rpm) && $stable(out_alive))
    else $error("stalled result changed");

  // A nonzero speed needs a live signal
  a_rpm_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rpm == '0) || out_alive)
    else $error("nonzero rpm without alive");

  // An accepted query keeps the input busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_QUERY) |=> in_stall)
    else $error("input not stalled after query");

  // A pulse word never raises a result
  a_pulse_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && !in_stall && (in_command == CMD_PULSE) |=> !out_valid)
    else $error("result after pulse word");

endmodule

bind pulse_period_tachometer ppt_checker u_ppt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_rpm    (out_rpm),
  .out_alive  (out_alive)
);

`default_nettype wire

FILE: verif/ppt_tacho_checker.sv
`timescale 1ns / 1ps

module ppt_tacho_checker
  import ppt_pkg::*;
#(
  parameter int SAMPLES = PPT_SAMPLES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_command,
  input  logic [PPT_TIME_W-1:0]    in_now_us,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [PPT_RPM_W-1:0]     out_rpm,
  input  logic                     out_alive,
  input  logic                     cfg_we,
  input  logic [PPT_TIMEOUT_W-1:0] cfg_wdata,
  output int                       mismatch_count,
  output int                       readings_pending,
  output int                       pulses_seen,
  output int                       readings_checked,
  output int                       saturated_readings,
  output int                       lost_readings
);

  localparam logic [63:0] RPM_CEILING = (64'd1 << PPT_RPM_W) - 1;

  typedef struct packed {
    logic [PPT_RPM_W-1:0] rpm;
    logic                 alive;
  } speed_reading_t;

  // Shadow copy of the tachometer state
  logic [PPT_TIME_W-1:0]    period_hist [SAMPLES];
  int                       hist_slot;
  logic [PPT_TIME_W-1:0]    last_pulse_us;
  logic                     pulse_seen;
  logic                     hist_full;
  logic [PPT_TIMEOUT_W-1:0] timeout_ms;

  speed_reading_t           expected_readings [$];
  speed_reading_t           oldest;

  // Store the wrapped period since the previous pulse, once one exists
  function automatic void log_pulse(logic [PPT_TIME_W-1:0] stamp);
    if (pulse_seen) begin
      period_hist[hist_slot] = stamp - last_pulse_us;
      hist_slot = (hist_slot + 1) % SAMPLES;
      if (hist_slot == 0) begin
        hist_full = 1'b1;
      end
    end
    pulse_seen = 1'b1;
    last_pulse_us = stamp;
  endfunction

  // Work out rpm and liveness for a query at the given stamp
  function automatic speed_reading_t predict_reading(logic [PPT_TIME_W-1:0] stamp);
    logic [PPT_TIME_W-1:0] elapsed;
    logic [63:0]           sum;
    logic [63:0]           mean;
    logic [63:0]           quotient;
    logic                  live;
    speed_reading_t        reading;
    int                    k;
    elapsed = stamp - last_pulse_us;
    live = 64'(elapsed) <= 64'(timeout_ms) * 64'(PPT_US_PER_MS);
    reading.rpm = '0;
    reading.alive = pulse_seen && live;
    if (hist_full && live) begin
      sum = '0;
      for (k = 0; k < SAMPLES; k++) begin
        sum = sum + 64'(period_hist[k]);
      end
      mean = sum / 64'(SAMPLES);
      if (mean == 0) begin
        reading.rpm = '1;
      end else begin
        quotient = 64'(PPT_RPM_NUM) / mean;
        reading.rpm = (quotient > RPM_CEILING) ? '1 : quotient[PPT_RPM_W-1:0];
      end
    end
    return reading;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (period_hist[k]) period_hist[k] = '0;
      hist_slot = 0;
      last_pulse_us = '0;
      pulse_seen = 1'b0;
      hist_full = 1'b0;
      timeout_ms = PPT_TIMEOUT_W'(PPT_TIMEOUT_RESET);
      expected_readings.delete();
      mismatch_count = 0;
      pulses_seen = 0;
      readings_checked = 0;
      saturated_readings = 0;
      lost_readings = 0;
    end else begin
      // Latch a timeout write
      if (cfg_we) begin
        timeout_ms = cfg_wdata;
      end

      // Compare a delivered reading with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: reading rpm %0d alive %0b arrived with none pending",
                     $realtime, out_rpm, out_alive);
          end
          mismatch_count++;
        end else begin
          oldest = expected_readings.pop_front();
          if (out_rpm !== oldest.rpm || out_alive !== oldest.alive) begin
            if (mismatch_count < 10) begin
              $display("%0t: reading %0d: expected rpm %0d alive %0b, got rpm %0d alive %0b",
                       $realtime, readings_checked, oldest.rpm, oldest.alive,
                       out_rpm, out_alive);
            end
            mismatch_count++;
          end
          readings_checked++;
          if (oldest.rpm == '1) saturated_readings++;
          if (!oldest.alive) lost_readings++;
        end
      end

      // Advance the model on an accepted word
      if (in_valid && !in_stall) begin
        if (in_command == CMD_PULSE) begin
          log_pulse(in_now_us);
          pulses_seen++;
        end else begin
          expected_readings.push_back(predict_reading(in_now_us));
        end
      end
    end
    readings_pending = expected_readings.size();
  end

endmodule

FILE: verif/tb_pulse_period_tachometer.sv
`timescale 1ns / 1ps

module tb_pulse_period_tachometer;
  import ppt_pkg::*;

  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_WORDS    = 150;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_command = CMD_PULSE;
  logic [PPT_TIME_W-1:0]    in_now_us = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [PPT_RPM_W-1:0]     out_rpm;
  logic                     out_alive;
  logic                     cfg_we = 1'b0;
  logic [PPT_TIMEOUT_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int readings_pending;
  int pulses_seen;
  int readings_checked;
  int saturated_readings;
  int lost_readings;

  int                       words_sent = 0;
  int                       idle_cycles = 0;
  int                       quiet_words = 0;
  int                       settings_used = 1;
  logic [PPT_TIME_W-1:0]    clock_us = '0;
  logic [PPT_TIME_W-1:0]    last_pulse_us = '0;
  logic [PPT_TIMEOUT_W-1:0] timeout_now = PPT_TIMEOUT_W'(PPT_TIMEOUT_RESET);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pulse_period_tachometer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_now_us  (in_now_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rpm    (out_rpm),
    .out_alive  (out_alive),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  ppt_tacho_checker tacho_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_now_us          (in_now_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rpm            (out_rpm),
    .out_alive          (out_alive),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatch_count     (mismatch_count),
    .readings_pending   (readings_pending),
    .pulses_seen        (pulses_seen),
    .readings_checked   (readings_checked),
    .saturated_readings (saturated_readings),
    .lost_readings      (lost_readings)
  );

  // Pause length: mostly none or short, now and then long
  function automatic int random_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Gap before the next word, with occasional back-to-back runs
  function automatic int next_gap();
    if (quiet_words > 0) begin
      quiet_words--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      quiet_words = $urandom_range(10, 40);
      return 0;
    end
    return random_pause();
  endfunction

  // Offset of a query from the last pulse, biased to the timeout boundary
  function automatic logic [PPT_TIME_W-1:0] pick_elapsed();
    logic [PPT_TIME_W-1:0] limit_us;
    int                    roll;
    limit_us = PPT_TIME_W'(timeout_now);
    limit_us = limit_us * PPT_US_PER_MS;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, limit_us);
    if (roll < 55) return limit_us;
    if (roll < 70) return limit_us + 1;
    if (roll < 90) return $urandom_range(0, 2 * limit_us + 2);
    return $urandom;
  endfunction

  // Pulse period: zero, saturating, normal, slow or anything at all
  function automatic logic [PPT_TIME_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return $urandom_range(0, 3);
    if (roll < 25) return $urandom_range(4, 915);
    if (roll < 80) return $urandom_range(916, 200000);
    if (roll < 95) return $urandom_range(200001, 9000000);
    return $urandom;
  endfunction

  // Drive one word and hold it until accepted; starts and ends at a falling edge
  task automatic send_word(logic cmd, logic [PPT_TIME_W-1:0] stamp);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_now_us  <= stamp;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    words_sent++;
    clock_us = stamp;
    if (cmd == CMD_PULSE) last_pulse_us = stamp;
  endtask

  // Write the timeout once every reading is back and the block is quiet
  task automatic write_timeout(logic [PPT_TIMEOUT_W-1:0] value);
    in_valid <= 1'b0;
    while (readings_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    timeout_now = value;
    settings_used++;
  endtask

  // Mostly steady pulse trains followed by queries, plus stray words and jumps
  task automatic run_phase(int words);
    int                    stop_at;
    int                    roll;
    logic [PPT_TIME_W-1:0] period;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        period = pick_period();
        repeat ($urandom_range(1, PPT_SAMPLES + 2)) begin
          send_word(CMD_PULSE, last_pulse_us + period + $urandom_range(0, period >> 6));
        end
        repeat ($urandom_range(1, 2)) send_word(CMD_QUERY, last_pulse_us + pick_elapsed());
      end else if (roll < 75) begin
        send_word(CMD_QUERY, last_pulse_us + pick_elapsed());
      end else if (roll < 88) begin
        send_word(CMD_PULSE, clock_us + pick_period());
      end else begin
        send_word(CMD_PULSE, $urandom);
      end
    end
  endtask

  // Receiver stalls: random holds, with long free-running stretches
  initial begin : stall_gen
    int hold;
    int run;
    @(negedge clk);
    forever begin
      hold = random_pause();
      run = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat (run) @(negedge clk);
    end
  end

  // Drop the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int                       i;
    logic [PPT_TIMEOUT_W-1:0] setting;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Query before any pulse, then a first pulse that records nothing
    send_word(CMD_QUERY, '0);
    send_word(CMD_PULSE, 32'hFFFF_F000);
    send_word(CMD_QUERY, 32'hFFFF_F00A);

    // Fill the history across the timestamp wrap: 3000 rpm
    repeat (PPT_SAMPLES) send_word(CMD_PULSE, last_pulse_us + 20000);
    send_word(CMD_QUERY, last_pulse_us + 5);

    // Identical stamps give a zero mean period
    repeat (PPT_SAMPLES) send_word(CMD_PULSE, last_pulse_us);
    send_word(CMD_QUERY, last_pulse_us);

    // Short periods push the quotient past 16 bits; probe the timeout edge
    repeat (PPT_SAMPLES) send_word(CMD_PULSE, last_pulse_us + 100);
    send_word(CMD_QUERY, last_pulse_us + 500000);
    send_word(CMD_QUERY, last_pulse_us + 500001);

    // Largest wrapped period rounds the speed down to zero
    repeat (PPT_SAMPLES) send_word(CMD_PULSE, last_pulse_us - 1);
    send_word(CMD_QUERY, last_pulse_us);

    // Zero timeout: live only at zero elapsed time
    write_timeout('0);
    send_word(CMD_QUERY, last_pulse_us);
    send_word(CMD_QUERY, last_pulse_us + 1);

    // Random phases over a spread of timeouts, extremes included
    for (i = 0; i < RANDOM_PHASES; i++) begin
      case (i)
        0: begin
          setting = PPT_TIMEOUT_W'(1);
        end
        1: begin
          setting = '1;
        end
        2: begin
          setting = PPT_TIMEOUT_W'(4294);
        end
        4: begin
          setting = '0;
        end
        5: begin
          setting = PPT_TIMEOUT_W'(PPT_TIMEOUT_RESET);
        end
        default: begin
          setting = PPT_TIMEOUT_W'($urandom_range(1, 4294));
        end
      endcase
      write_timeout(setting);
      run_phase(PHASE_WORDS);
    end

    // Drain the remaining readings
    in_valid <= 1'b0;
    while (readings_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d words (%0d pulses) under %0d timeout settings, stamps wrapping.",
             words_sent, pulses_seen, settings_used);
    $display("Checked %0d speed readings: %0d saturated, %0d with no live signal.",
             readings_checked, saturated_readings, lost_readings);
    if (mismatch_count == 0 && readings_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
